// ===== hdl/rtla_pkg.sv =====
// Shared types and opcodes for the record table.
// No dependencies; used by rtla_cell and record_table_alloc_lookup.
package rtla_pkg;

    localparam int TableEntriesDef = 64;
    localparam int OpW             = 3;
    localparam int KeyW            = 32;
    localparam int SectorW         = 16;
    localparam int SalaryW         = 32;
    localparam int IdW             = 32;
    localparam int OutIdxW         = 6;

    localparam logic [OpW-1:0] OP_INSERT      = 3'd0;
    localparam logic [OpW-1:0] OP_DELETE      = 3'd1;
    localparam logic [OpW-1:0] OP_FIND_ID     = 3'd2;
    localparam logic [OpW-1:0] OP_FIND_SECTOR = 3'd3;
    localparam logic [OpW-1:0] OP_DELETE_ALL  = 3'd4;

    // Command word travelling down the row of cells
    typedef struct packed {
        logic               active;
        logic               done;   // a cell has already claimed the command
        logic [OpW-1:0]     op;
        logic [KeyW-1:0]    key;
        logic [SectorW-1:0] sector;
        logic [SalaryW-1:0] salary;
        logic [IdW-1:0]     new_id;
    } t_token;

endpackage

// ===== hdl/rtla_cell.sv =====
// One table entry plus one stage of the command pipeline.
// Depends on rtla_pkg.
module rtla_cell #(
    parameter int IdxW      = 6,
    parameter int CellIndex = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtla_pkg::t_token i_tok,
    input  logic [IdxW-1:0] i_idx,
    output rtla_pkg::t_token o_tok,
    output logic [IdxW-1:0] o_idx
);
    import rtla_pkg::*;

    logic               r_valid;
    logic [IdW-1:0]     r_id;
    logic [SectorW-1:0] r_sector;
    logic [SalaryW-1:0] r_salary;
    t_token             r_tok;
    logic [IdxW-1:0]    r_idx;

    logic   n_valid;
    logic   take;   // insert lands here
    logic   claim;  // this cell ends the search
    logic   id_hit;
    logic   sec_hit;

    assign id_hit  = (r_id == i_tok.key);
    assign sec_hit = ({{(KeyW-SectorW){1'b0}}, r_sector} == i_tok.key);

    always_comb begin
        n_valid = r_valid;
        take    = 1'b0;
        claim   = 1'b0;
        if (i_tok.active) begin
            unique case (i_tok.op)
                OP_INSERT: begin
                    if (!i_tok.done && !r_valid) begin
                        take    = 1'b1;
                        claim   = 1'b1;
                        n_valid = 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (!i_tok.done && r_valid && id_hit) begin
                        claim   = 1'b1;
                        n_valid = 1'b0;
                    end
                end
                OP_FIND_ID: begin
                    claim = !i_tok.done && r_valid && id_hit;
                end
                OP_FIND_SECTOR: begin
                    claim = !i_tok.done && r_valid && sec_hit;
                end
                OP_DELETE_ALL: begin
                    // stale ids of empty entries are harmless: clearing again is a no-op
                    if (id_hit) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_tok.active <= i_tok.active;
        end
        if (take) begin
            r_id     <= i_tok.new_id;
            r_sector <= i_tok.sector;
            r_salary <= i_tok.salary;
        end
        r_tok.done   <= i_tok.done | claim;
        r_tok.op     <= i_tok.op;
        r_tok.key    <= i_tok.key;
        r_tok.sector <= i_tok.sector;
        r_tok.salary <= i_tok.salary;
        r_tok.new_id <= i_tok.new_id;
        r_idx        <= claim ? IdxW'(CellIndex) : i_idx;
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

    // salary is held for the record but never read back
    logic unused_salary;
    assign unused_salary = ^r_salary;

endmodule

// ===== hdl/record_table_alloc_lookup.sv =====
// Top level of the record table: command register, row of cells, result stage.
// Depends on rtla_pkg and rtla_cell.
//
// Usage
//   Command channel: drive i_opcode, i_search_key, i_new_sector and
//   i_new_salary_cents with start high; the word is taken at the clock edge
//   where start is high and busy is low. busy stays high until the result
//   word is issued.
//   Result channel: o_strobe is high for one cycle with o_status,
//   o_entry_index and o_assigned_id. There is no back-pressure; the result
//   must be taken in that cycle.
//   The word is registered at the accepting edge, walks the row of cells one
//   entry per cycle and is registered once more in the result stage, which
//   raises the strobe. busy drops in the cycle the strobe shows, so the next
//   word is taken at the edge that ends it; one command is in flight at a time.
//   Reset (synchronous, i_rst_n low) empties every entry and zeroes the id
//   counter; nothing needs sweeping afterwards.
module record_table_alloc_lookup #(
    parameter int TABLE_ENTRIES = rtla_pkg::TableEntriesDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rtla_pkg::OpW-1:0]     i_opcode,
    input  logic [rtla_pkg::KeyW-1:0]    i_search_key,
    input  logic [rtla_pkg::SectorW-1:0] i_new_sector,
    input  logic [rtla_pkg::SalaryW-1:0] i_new_salary_cents,
    output logic                         o_strobe,
    output logic                         o_status,
    output logic [rtla_pkg::OutIdxW-1:0] o_entry_index,
    output logic [rtla_pkg::IdW-1:0]     o_assigned_id
);
    import rtla_pkg::*;

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_token          r_cmd;
    logic            r_busy;
    logic [IdW-1:0]  r_counter;
    logic            r_strobe;
    logic            r_status;
    logic [OutIdxW-1:0] r_index;
    logic [IdW-1:0]  r_assigned;

    t_token          tok [0:TABLE_ENTRIES];
    logic [IdxW-1:0] idx [0:TABLE_ENTRIES];

    logic            accept;
    t_token          tail;
    logic [IdxW+OutIdxW-1:0] tail_idx_ext;
    logic            tail_insert_ok;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Command register: feeds cell 0 for exactly one cycle per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd.active <= 1'b0;
        end else begin
            r_cmd.active <= accept;
        end
        if (accept) begin
            r_cmd.done   <= 1'b0;
            r_cmd.op     <= i_opcode;
            r_cmd.key    <= i_search_key;
            r_cmd.sector <= i_new_sector;
            r_cmd.salary <= i_new_salary_cents;
            r_cmd.new_id <= r_counter + IdW'(1);   // pre-increment
        end
    end

    assign tok[0] = r_cmd;
    assign idx[0] = '0;

    // Row of cells, one per entry; word moves one cell per cycle
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rtla_cell #(
            .IdxW      (IdxW),
            .CellIndex (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .i_idx   (idx[g]),
            .o_tok   (tok[g+1]),
            .o_idx   (idx[g+1])
        );
    end

    assign tail           = tok[TABLE_ENTRIES];
    assign tail_idx_ext   = {{OutIdxW{1'b0}}, idx[TABLE_ENTRIES]};
    assign tail_insert_ok = (tail.op == OP_INSERT) && tail.done;

    // Busy, id counter and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_counter <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= tail.active;
            // accept and the tail never coincide: one command in flight
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail.active) begin
                r_busy <= 1'b0;
            end
            // counter only moves when an insert found a free entry
            if (tail.active && tail_insert_ok) begin
                r_counter <= tail.new_id;
            end
        end
    end

    // Result word: index truncated to its low bits for deep tables
    always_ff @(posedge i_clk) begin
        if (tail.active) begin
            r_status   <= !(tail.done || (tail.op == OP_DELETE_ALL));
            r_index    <= tail.done ? tail_idx_ext[OutIdxW-1:0] : '0;
            r_assigned <= tail_insert_ok ? tail.new_id : '0;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_index = r_index;
    assign o_assigned_id = r_assigned;

`ifndef NO_ASSERTIONS
    // a result only closes a command that was in flight
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a command in flight");

    // accepted word keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // one command in flight means no back-to-back results
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result strobes in a row");

    // an id handed out means a successful insert, and the counter matches it
    a_id_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_assigned_id != '0) |-> (!o_status && r_counter == o_assigned_id))
        else $error("assigned id disagrees with counter or status");
`endif

endmodule
